### rtl/circular_list_cursor_queue_top_assert.svh
// Assertion macros used by the queue controller RTL.
`ifndef CIRCULAR_LIST_CURSOR_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_LIST_CURSOR_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CLCQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clcq assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CLCQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clcq assertion failed");

`endif

### rtl/clcq_pkg.sv
// Package: sizes, codes, memory request types and helpers for the queue.
`timescale 1ns / 1ps
package clcq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_ENQ  = 3'd0,
    OP_DEQ  = 3'd1,
    OP_ROT  = 3'd2,
    OP_PEEK = 3'd3,
    OP_CLR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Request to a memory that holds node indexes (links, free stack).
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
  } idx_req_t;

  // Request to the payload memory.
  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
  } pay_req_t;

  // Out-of-range node index maps to node zero.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] i);
    return (int'(i) < CAPACITY) ? i : '0;
  endfunction

endpackage

### rtl/clcq_in_if.sv
// Input channel: operation code and payload with valid/ready.
`timescale 1ns / 1ps
interface clcq_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 op;
  logic [clcq_pkg::DATA_W-1:0] payload;

  modport source (output valid, output op, output payload, input ready);
  modport sink   (input valid, input op, input payload, output ready);
endinterface

### rtl/clcq_out_if.sv
// Result channel: read data, status, count and empty flag with valid/ready.
`timescale 1ns / 1ps
interface clcq_out_if;
  logic                        valid;
  logic                        ready;
  logic [clcq_pkg::DATA_W-1:0] read_data;
  logic [1:0]                  status;
  logic [clcq_pkg::CNT_W-1:0]  entry_count;
  logic                        is_empty;

  modport source (output valid, output read_data, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_data, input status, input entry_count,
                  input is_empty, output ready);
endinterface

### rtl/clcq_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
`timescale 1ns / 1ps
module clcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/clcq_ctrl.sv
// Sequencer: ring registers, read-modify-write of the node memories, result register.
`timescale 1ns / 1ps
module clcq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  clcq_in_if.sink                     in_ch,
  clcq_out_if.source                  out_ch,
  output clcq_pkg::idx_req_t          link_req,
  input  logic [clcq_pkg::IDX_W-1:0]  link_rdata,
  output clcq_pkg::idx_req_t          fs_req,
  input  logic [clcq_pkg::IDX_W-1:0]  fs_rdata,
  output clcq_pkg::pay_req_t          pay_req,
  input  logic [clcq_pkg::DATA_W-1:0] pay_rdata
);

`include "circular_list_cursor_queue_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EX1  = 3'b010,
    ST_EX2  = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  clcq_pkg::op_t                 op_r, op_nxt;
  logic [clcq_pkg::DATA_W-1:0]   payload_r, payload_nxt;
  logic [clcq_pkg::IDX_W-1:0]    node_r, node_nxt;
  logic [clcq_pkg::IDX_W-1:0]    cursor_r, cursor_nxt;
  logic [clcq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [clcq_pkg::CNT_W-1:0]    free_top_r, free_top_nxt;
  logic [clcq_pkg::CNT_W-1:0]    nu_r, nu_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [clcq_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  clcq_pkg::status_t             out_stat_r, out_stat_nxt;
  logic [clcq_pkg::CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic                          stack_ok;
  logic                          pool_full;
  logic                          ring_empty;
  logic [clcq_pkg::IDX_W-1:0]    alloc_node;
  logic [clcq_pkg::IDX_W-1:0]    cur_next;
  logic [clcq_pkg::CNT_W-1:0]    top_dec;
  logic                          done;
  logic [clcq_pkg::DATA_W-1:0]   rd;
  clcq_pkg::status_t             stat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign top_dec    = free_top_r - 1'b1;
  assign stack_ok   = (free_top_r != '0) &&
                      (free_top_r <= clcq_pkg::CNT_W'(clcq_pkg::CAPACITY));
  assign pool_full  = !stack_ok && (nu_r >= clcq_pkg::CNT_W'(clcq_pkg::CAPACITY));
  assign ring_empty = (count_r == '0);
  assign alloc_node = stack_ok ? clcq_pkg::slot(fs_rdata) : nu_r[clcq_pkg::IDX_W-1:0];
  assign cur_next   = clcq_pkg::slot(link_rdata);

  always_comb begin
    // Reads are launched at accept from the current cursor; a dequeue chases
    // the victim's link and payload with a second read.
    link_req.re    = in_fire || (state_r == ST_EX1 && op_r == clcq_pkg::OP_DEQ && !ring_empty);
    link_req.raddr = (state_r == ST_EX1) ? cur_next : cursor_r;
    pay_req.re     = link_req.re;
    pay_req.raddr  = link_req.raddr;
    fs_req.re      = in_fire;
    fs_req.raddr   = top_dec[clcq_pkg::IDX_W-1:0];

    state_nxt     = state_r;
    op_nxt        = op_r;
    payload_nxt   = payload_r;
    node_nxt      = node_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    free_top_nxt  = free_top_r;
    nu_nxt        = nu_r;
    link_req.we    = 1'b0;
    link_req.waddr = cursor_r;
    link_req.wdata = cur_next;
    pay_req.we     = 1'b0;
    pay_req.waddr  = alloc_node;
    pay_req.wdata  = payload_r;
    fs_req.we      = 1'b0;
    fs_req.waddr   = free_top_r[clcq_pkg::IDX_W-1:0];
    fs_req.wdata   = node_r;
    done = 1'b0;
    rd   = '0;
    stat = clcq_pkg::STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt   = ST_EX1;
          op_nxt      = clcq_pkg::op_t'(in_ch.op);
          payload_nxt = in_ch.payload;
        end
      end
      ST_EX1: begin
        case (op_r)
          clcq_pkg::OP_ENQ: begin
            if (pool_full) begin
              stat = clcq_pkg::STAT_FULL;
              done = out_free;
            end else if (!ring_empty || out_free) begin
              if (stack_ok) begin
                free_top_nxt = top_dec;
              end else begin
                nu_nxt = nu_r + 1'b1;
              end
              count_nxt      = count_r + 1'b1;
              pay_req.we     = 1'b1;
              link_req.we    = 1'b1;
              link_req.waddr = alloc_node;
              if (ring_empty) begin
                link_req.wdata = alloc_node;
                cursor_nxt     = alloc_node;
                done           = 1'b1;
              end else begin
                // new node takes the cursor's old successor; cursor relinks next
                link_req.wdata = cur_next;
                node_nxt       = alloc_node;
                state_nxt      = ST_EX2;
              end
            end
          end
          clcq_pkg::OP_DEQ: begin
            if (ring_empty) begin
              stat = clcq_pkg::STAT_EMPTY;
              done = out_free;
            end else begin
              node_nxt  = cur_next;
              state_nxt = ST_EX2;
            end
          end
          clcq_pkg::OP_ROT: begin
            if (out_free) begin
              if (!ring_empty) begin
                cursor_nxt = cur_next;
              end
              done = 1'b1;
            end
          end
          clcq_pkg::OP_PEEK: begin
            if (ring_empty) begin
              stat = clcq_pkg::STAT_EMPTY;
            end else begin
              rd = pay_rdata;
            end
            done = out_free;
          end
          clcq_pkg::OP_CLR: begin
            if (out_free) begin
              count_nxt    = '0;
              free_top_nxt = '0;
              nu_nxt       = '0;
              cursor_nxt   = '0;
              done         = 1'b1;
            end
          end
          default: begin
            done = out_free;
          end
        endcase
      end
      ST_EX2: begin
        if (out_free) begin
          done = 1'b1;
          if (op_r == clcq_pkg::OP_DEQ) begin
            rd = pay_rdata;
            if (node_r == cursor_r || count_r == clcq_pkg::CNT_W'(1)) begin
              cursor_nxt = '0;
            end else begin
              link_req.we = 1'b1;
            end
            if (free_top_r < clcq_pkg::CNT_W'(clcq_pkg::CAPACITY)) begin
              fs_req.we    = 1'b1;
              free_top_nxt = free_top_r + 1'b1;
            end
            count_nxt = count_r - 1'b1;
          end else begin
            link_req.we    = 1'b1;
            link_req.wdata = node_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = done || (out_valid_r && !out_ch.ready);
    out_data_nxt  = done ? rd : out_data_r;
    out_stat_nxt  = done ? stat : out_stat_r;
    out_cnt_nxt   = done ? count_nxt : out_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      count_r     <= '0;
      free_top_r  <= '0;
      nu_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      free_top_r  <= free_top_nxt;
      nu_r        <= nu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    payload_r  <= payload_nxt;
    node_r     <= node_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.is_empty    = (out_cnt_r == '0);

  // every handed-out node is either in the ring or on the free stack
  `CLCQ_ASSERT_IMPL(a_node_balance, 1'b1, (count_r + free_top_r) == nu_r)
  `CLCQ_ASSERT_IMPL(a_count_max, 1'b1, count_r <= clcq_pkg::CNT_W'(clcq_pkg::CAPACITY))
  `CLCQ_ASSERT_NEXT(a_accept_starts, in_fire, state_r == ST_EX1)
  `CLCQ_ASSERT_IMPL(a_done_slot_free, done, out_free)

endmodule

### rtl/circular_list_cursor_queue_top.sv
// An operation is accepted in IDLE and finishes in EX1 for rotate, peek, clear,
// rejected ops and enqueue into an empty ring; dequeue and enqueue into a non-empty
// ring go on to EX2 for the chained link-memory reads (cursor link, then victim
// link) and the second link write of an insert. Input is ready only in IDLE.
// Reset: synchronous, clears cursor, count and the free-pool counters; node
// memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module circular_list_cursor_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  clcq_in_if.sink    in_ch,
  clcq_out_if.source out_ch
);

  clcq_pkg::idx_req_t          link_req;
  clcq_pkg::idx_req_t          fs_req;
  clcq_pkg::pay_req_t          pay_req;
  logic [clcq_pkg::IDX_W-1:0]  link_rdata;
  logic [clcq_pkg::IDX_W-1:0]  fs_rdata;
  logic [clcq_pkg::DATA_W-1:0] pay_rdata;

  clcq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .link_req   (link_req),
    .link_rdata (link_rdata),
    .fs_req     (fs_req),
    .fs_rdata   (fs_rdata),
    .pay_req    (pay_req),
    .pay_rdata  (pay_rdata)
  );

  clcq_ram #(.WIDTH(clcq_pkg::IDX_W), .DEPTH(clcq_pkg::CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .re    (link_req.re),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  clcq_ram #(.WIDTH(clcq_pkg::IDX_W), .DEPTH(clcq_pkg::CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (fs_req.we),
    .waddr (fs_req.waddr),
    .wdata (fs_req.wdata),
    .re    (fs_req.re),
    .raddr (fs_req.raddr),
    .rdata (fs_rdata)
  );

  clcq_ram #(.WIDTH(clcq_pkg::DATA_W), .DEPTH(clcq_pkg::CAPACITY)) u_pay_ram (
    .clk   (clk),
    .we    (pay_req.we),
    .waddr (pay_req.waddr),
    .wdata (pay_req.wdata),
    .re    (pay_req.re),
    .raddr (pay_req.raddr),
    .rdata (pay_rdata)
  );

endmodule

### tb/circular_list_cursor_queue_checker.sv
// Scoreboard for the cursor queue: mirrors the ring state and checks every result transaction.
`timescale 1ns / 1ps
module circular_list_cursor_queue_checker
  import clcq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  clcq_in_if   in_ch,
  clcq_out_if  out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
  } ring_result_t;

  logic [DATA_W-1:0] node_word[CAPACITY];
  logic [IDX_W-1:0]  node_next[CAPACITY];
  logic [IDX_W-1:0]  spare_nodes[CAPACITY];
  logic [CNT_W-1:0]  spare_top;
  logic [CNT_W-1:0]  fresh_mark;
  logic [IDX_W-1:0]  cursor_node;
  logic [CNT_W-1:0]  ring_len;
  ring_result_t      ring_results_q[$];
  int                txn_out;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t result %0d: %s got 0x%0h, expected 0x%0h", $time, txn_out, what, got,
             want);
    errors++;
  endtask

  // Applies one operation to the mirrored ring and returns the result it should produce.
  function automatic ring_result_t apply_op(input logic [2:0] code,
                                            input logic [DATA_W-1:0] word);
    ring_result_t     r;
    logic [IDX_W-1:0] node;
    logic             got_node;
    r = '0;
    r.status = STAT_OK;
    node = '0;
    case (code)
      OP_ENQ: begin
        got_node = 1'b1;
        // recycled nodes first, then untouched ones in index order
        if (spare_top != 0) begin
          spare_top = spare_top - 1'b1;
          node = spare_nodes[spare_top[IDX_W-1:0]];
        end else if (fresh_mark < CAPACITY) begin
          node = fresh_mark[IDX_W-1:0];
          fresh_mark = fresh_mark + 1'b1;
        end else begin
          got_node = 1'b0;
        end
        if (!got_node) begin
          r.status = STAT_FULL;
        end else begin
          node_word[node] = word;
          if (ring_len == 0) begin
            node_next[node] = node;
            cursor_node = node;
          end else begin
            node_next[node] = node_next[cursor_node];
            node_next[cursor_node] = node;
          end
          ring_len = ring_len + 1'b1;
        end
      end
      OP_DEQ: begin
        if (ring_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          node = node_next[cursor_node];
          r.read_data = node_word[node];
          if (node == cursor_node || ring_len == 1)
            cursor_node = '0;
          else
            node_next[cursor_node] = node_next[node];
          if (spare_top < CAPACITY) begin
            spare_nodes[spare_top[IDX_W-1:0]] = node;
            spare_top = spare_top + 1'b1;
          end
          ring_len = ring_len - 1'b1;
        end
      end
      OP_ROT: begin
        if (ring_len != 0)
          cursor_node = node_next[cursor_node];
      end
      OP_PEEK: begin
        if (ring_len == 0)
          r.status = STAT_EMPTY;
        else
          r.read_data = node_word[cursor_node];
      end
      OP_CLR: begin
        ring_len = '0;
        spare_top = '0;
        fresh_mark = '0;
        cursor_node = '0;
      end
      default: begin
      end
    endcase
    r.entry_count = ring_len;
    r.is_empty = (ring_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      spare_top = '0;
      fresh_mark = '0;
      cursor_node = '0;
      ring_len = '0;
      txn_out = 0;
      ring_results_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (ring_results_q.size() == 0) begin
          report_mismatch("unexpected transaction, read_data", out_ch.read_data, '0);
        end else begin
          want = ring_results_q.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.status !== want.status)
            report_mismatch("status", DATA_W'(out_ch.status), DATA_W'(want.status));
          if (out_ch.entry_count !== want.entry_count)
            report_mismatch("entry_count", DATA_W'(out_ch.entry_count),
                            DATA_W'(want.entry_count));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", DATA_W'(out_ch.is_empty), DATA_W'(want.is_empty));
        end
        txn_out++;
      end
      if (in_ch.valid && in_ch.ready)
        ring_results_q.push_back(apply_op(in_ch.op, in_ch.payload));
    end
    pending = ring_results_q.size();
  end

endmodule

### tb/circular_list_cursor_queue_top_test.sv
// Testbench top: clock, reset, operation stimulus with idling and stall phases, and the verdict.
`timescale 1ns / 1ps
module circular_list_cursor_queue_top_test;
  import clcq_pkg::*;

  // codes past clear are reserved; the block must answer them without any change
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  typedef enum {MIX_BLEND, MIX_FILL, MIX_DRAIN} traffic_t;

  logic clk;
  logic rst_n;
  int   err_count;
  int   pending_count;
  int   in_idle_pct;
  int   out_stall_pct;

  clcq_in_if  in_ch ();
  clcq_out_if out_ch ();

  circular_list_cursor_queue_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  circular_list_cursor_queue_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (err_count),
    .pending (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_op(input logic [2:0] code, input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= code;
    in_ch.payload <= word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(15);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(input traffic_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MIX_FILL:  return (r < 95) ? OP_ENQ : (r < 97) ? OP_ROT : OP_PEEK;
      MIX_DRAIN: return (r < 92) ? OP_DEQ : (r < 95) ? OP_ENQ : (r < 98) ? OP_ROT : OP_PEEK;
      default: begin
        if (r < 35)
          return OP_ENQ;
        if (r < 60)
          return OP_DEQ;
        if (r < 75)
          return OP_ROT;
        if (r < 87)
          return OP_PEEK;
        if (r < 93)
          return OP_CLR;
        return 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      end
    endcase
  endfunction

  task automatic run_burst(input traffic_t mode, input int n);
    for (int i = 0; i < n; i++)
      push_op(pick_op(mode), pick_word());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_ENQ;
    in_ch.payload  = '0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ring corner cases
    push_op(OP_PEEK, '1);
    push_op(OP_DEQ, '1);
    push_op(OP_ROT, '0);
    push_op(OP_RSVD_LO, 32'hDEAD_BEEF);
    // single entry links to itself and becomes the cursor
    push_op(OP_ENQ, 32'hFFFF_FFFF);
    push_op(OP_PEEK, '0);
    push_op(OP_ROT, '0);
    push_op(OP_PEEK, '0);
    push_op(OP_ENQ, 32'h0000_0000);
    push_op(OP_ENQ, 32'hA5A5_A5A5);
    push_op(OP_PEEK, '0);
    push_op(OP_ROT, '0);
    push_op(OP_PEEK, '0);
    push_op(OP_DEQ, '0);
    push_op(OP_DEQ, '0);
    // last entry leaves: ring empties and the cursor returns to node zero
    push_op(OP_DEQ, '0);
    push_op(OP_DEQ, '0);
    // nodes now come off the free stack
    push_op(OP_ENQ, 32'h5A5A_5A5A);
    push_op(OP_ENQ, 32'h0000_0001);
    push_op(OP_CLR, '1);
    push_op(OP_PEEK, '0);
    push_op(OP_ENQ, 32'h8000_0000);
    push_op(OP_RSVD_MID, '1);
    push_op(OP_RSVD_HI, '1);
    push_op(OP_DEQ, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 71;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 71;
        end
        default: begin
          in_idle_pct = 13;
          out_stall_pct = 13;
        end
      endcase
      run_burst(MIX_BLEND, 6);
      // long enqueue run drives the pool to full, then drain past empty
      run_burst(MIX_FILL, 70);
      run_burst(MIX_DRAIN, 74);
    end

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/clcq_pkg.sv
rtl/clcq_in_if.sv
rtl/clcq_out_if.sv
rtl/clcq_ram.sv
rtl/clcq_ctrl.sv
rtl/circular_list_cursor_queue_top.sv
tb/circular_list_cursor_queue_checker.sv
tb/circular_list_cursor_queue_top_test.sv
